### hw/rtl/mgps_pkg.sv
`timescale 1ns / 1ps
// Shared constants, word types and state encodings of the masked gather product-sum unit.
package mgps_pkg;

  localparam int MAP_LEN = 64;
  localparam int X_DEPTH = 4096;
  localparam int Q_DEPTH = 4096;

  localparam int MAP_AW = $clog2(MAP_LEN);
  localparam int X_AW   = $clog2(X_DEPTH);
  localparam int Q_AW   = $clog2(Q_DEPTH);

  localparam int ADDR_W    = 12;
  localparam int VAL_W     = 32;
  localparam int MAP_W     = 7;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;
  localparam int IDX_W     = 6;
  localparam int ACC_W     = 2 * VAL_W;
  localparam int IX_W      = MAP_W + CFG_W + 1;

  localparam logic [CFG_W-1:0] X_STRIDE_RST = CFG_W'(64);
  localparam logic [CFG_W-1:0] Q_ROWS_RST   = CFG_W'(64);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_STRIDE = 1'b0,
    CFG_Q_ROWS   = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    REQ_ROW_MAP = 3'd0,
    REQ_COL_MAP = 3'd1,
    REQ_X       = 3'd2,
    REQ_Q       = 3'd3,
    REQ_PAIR    = 3'd4
  } req_type_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAP,
    ST_VAL,
    ST_ACC
  } state_t;

  typedef struct packed {
    logic [2:0]              req_type;
    logic [ADDR_W-1:0]       addr;
    logic signed [VAL_W-1:0] wdata;
    logic [IDX_W-1:0]        row_index;
    logic [IDX_W-1:0]        col_index;
    logic                    last;
  } in_word_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] total;
    logic                    saturated;
  } out_word_t;

  typedef struct packed {
    logic                    row_map_we;
    logic                    col_map_we;
    logic                    x_we;
    logic                    q_we;
    logic [ADDR_W-1:0]       addr;
    logic signed [VAL_W-1:0] wdata;
  } store_wr_t;

  typedef struct packed {
    logic mul_en;
    logic hit;
    logic acc_en;
    logic last;
  } mac_ctrl_t;

endpackage

### hw/rtl/mgps_store.sv
`timescale 1ns / 1ps
// Synchronous memories for the two index maps and the X and Q value matrices.
module mgps_store import mgps_pkg::*; (
  input  logic                    clk,
  input  store_wr_t               wr,
  input  logic                    map_rd_en,
  input  logic [MAP_AW-1:0]       row_rd_addr,
  input  logic [MAP_AW-1:0]       col_rd_addr,
  output logic [MAP_W-1:0]        row_map_r,
  output logic [MAP_W-1:0]        col_map_r,
  input  logic                    val_rd_en,
  input  logic [X_AW-1:0]         x_rd_addr,
  input  logic [Q_AW-1:0]         q_rd_addr,
  output logic signed [VAL_W-1:0] x_val_r,
  output logic signed [VAL_W-1:0] q_val_r
);

  logic [MAP_W-1:0]        row_map_mem [MAP_LEN];
  logic [MAP_W-1:0]        col_map_mem [MAP_LEN];
  logic signed [VAL_W-1:0] x_mem [X_DEPTH];
  logic signed [VAL_W-1:0] q_mem [Q_DEPTH];

  logic map_addr_ok;
  logic x_addr_ok;
  logic q_addr_ok;

  assign map_addr_ok = (wr.addr < MAP_LEN);
  assign x_addr_ok   = (wr.addr < X_DEPTH);
  assign q_addr_ok   = (wr.addr < Q_DEPTH);

  always_ff @(posedge clk) begin
    if (wr.row_map_we && map_addr_ok) begin
      row_map_mem[MAP_AW'(wr.addr)] <= wr.wdata[MAP_W-1:0];
    end
    if (map_rd_en) begin
      row_map_r <= row_map_mem[row_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr.col_map_we && map_addr_ok) begin
      col_map_mem[MAP_AW'(wr.addr)] <= wr.wdata[MAP_W-1:0];
    end
    if (map_rd_en) begin
      col_map_r <= col_map_mem[col_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr.x_we && x_addr_ok) begin
      x_mem[X_AW'(wr.addr)] <= wr.wdata;
    end
    if (val_rd_en) begin
      x_val_r <= x_mem[x_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr.q_we && q_addr_ok) begin
      q_mem[Q_AW'(wr.addr)] <= wr.wdata;
    end
    if (val_rd_en) begin
      q_val_r <= q_mem[q_rd_addr];
    end
  end

endmodule

### hw/rtl/mgps_mac.sv
`timescale 1ns / 1ps
// Product register, saturating 64-bit accumulator and result output register.
module mgps_mac import mgps_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  mac_ctrl_t               ctrl,
  input  logic signed [VAL_W-1:0] x_val,
  input  logic signed [VAL_W-1:0] q_val,
  input  logic                    out_ready,
  output logic                    out_valid,
  output out_word_t               out_word,
  output logic                    out_free
);

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  logic signed [ACC_W-1:0] prod_full;
  logic signed [ACC_W-1:0] prod_r;
  logic signed [ACC_W-1:0] prod_nxt;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] acc_nxt;
  logic                    sat_r;
  logic                    sat_nxt;
  logic                    out_valid_r;
  logic                    out_valid_nxt;
  out_word_t               out_word_r;
  logic [ACC_W:0]          sum_wide;
  logic                    ovf;
  logic signed [ACC_W-1:0] sum_sat;

  assign prod_full = x_val * q_val;
  assign prod_nxt  = ctrl.hit ? prod_full : '0;

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= prod_nxt;
    end
  end

  assign sum_wide = {acc_r[ACC_W-1], acc_r} + {prod_r[ACC_W-1], prod_r};
  assign ovf      = sum_wide[ACC_W] ^ sum_wide[ACC_W-1];
  assign sum_sat  = ovf ? (sum_wide[ACC_W] ? ACC_MIN : ACC_MAX) : sum_wide[ACC_W-1:0];

  always_comb begin
    acc_nxt       = acc_r;
    sat_nxt       = sat_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (ctrl.acc_en) begin
      acc_nxt = ctrl.last ? '0 : sum_sat;
      sat_nxt = ctrl.last ? 1'b0 : (sat_r || ovf);
      if (ctrl.last) begin
        out_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      sat_r       <= sat_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.acc_en && ctrl.last) begin
      out_word_r.total     <= sum_sat;
      out_word_r.saturated <= sat_r || ovf;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign out_free  = !out_valid_r || out_ready;

endmodule

### hw/rtl/masked_gather_product_sum_unit.sv
`timescale 1ns / 1ps
// Top level of the masked gather product-sum unit: request sequencer and configuration.
//
// The input channel (in_valid, in_ready, in_word) carries table writes and index pairs.
// A table write to a map, to X or to Q is taken while the unit is idle. An index pair
// reads both maps, then X and Q from the computed addresses, multiplies and accumulates:
// the two dependent synchronous memory reads are followed by the multiply and the
// accumulate, and in_ready stays low from each accepted pair until it leaves ST_ACC,
// so no new word is taken before the pair is through. A pair whose map entry is zero,
// or whose addresses fall outside X or Q, adds nothing.
// The word with last set yields one result word on out_valid, out_ready, out_word, in the
// cycle after its accumulate step; the accumulator and saturation flag then clear.
// The result sits in an output register, so the next requests are taken while it waits.
// If an earlier result is still held when a new last pair reaches its accumulate step,
// the unit waits there until out_ready frees the register.
// The cfg channel writes x_stride and q_rows; cfg_ready is always high, and writes must be
// made only while the unit is idle, which the unit itself does not enforce.
// Synchronous active-low reset clears the accumulator, the flag, the output valid and
// sets both strides to 64; the table contents are undefined until written.
module masked_gather_product_sum_unit import mgps_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_word_t             in_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_word_t            out_word,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  state_t                  state_r;
  state_t                  state_nxt;
  logic [CFG_W-1:0]        x_stride_r;
  logic [CFG_W-1:0]        q_rows_r;
  logic [IDX_W-1:0]        pair_row_r;
  logic [IDX_W-1:0]        pair_col_r;
  logic                    last_r;
  logic                    range_r;
  logic                    hit_r;
  logic                    hit_nxt;
  store_wr_t               wr;
  logic                    map_rd_en;
  logic                    val_rd_en;
  logic [MAP_W-1:0]        row_map_r;
  logic [MAP_W-1:0]        col_map_r;
  logic signed [VAL_W-1:0] x_val_r;
  logic signed [VAL_W-1:0] q_val_r;
  logic [MAP_W-1:0]        mi_m1;
  logic [MAP_W-1:0]        mj_m1;
  logic [IX_W-1:0]         ix;
  logic [IX_W-1:0]         iq;
  mac_ctrl_t               ctrl;
  logic                    out_free;
  logic                    pair_take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_stride_r <= X_STRIDE_RST;
      q_rows_r   <= Q_ROWS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_X_STRIDE: x_stride_r <= cfg_data;
        CFG_Q_ROWS:   q_rows_r   <= cfg_data;
      endcase
    end
  end

  assign pair_take = in_valid && in_ready && (in_word.req_type == REQ_PAIR);

  always_ff @(posedge clk) begin
    if (pair_take) begin
      pair_row_r <= in_word.row_index;
      pair_col_r <= in_word.col_index;
      last_r     <= in_word.last;
      range_r    <= (in_word.row_index < MAP_LEN) && (in_word.col_index < MAP_LEN);
    end
    if (state_r == ST_MAP) begin
      hit_r <= hit_nxt;
    end
  end

  assign mi_m1 = row_map_r - MAP_W'(1);
  assign mj_m1 = col_map_r - MAP_W'(1);
  assign ix    = IX_W'(mj_m1) * IX_W'(x_stride_r) + IX_W'(mi_m1);
  assign iq    = IX_W'(pair_col_r) * IX_W'(q_rows_r) + IX_W'(pair_row_r);

  assign hit_nxt = range_r && (row_map_r != '0) && (col_map_r != '0) &&
                   (ix < X_DEPTH) && (iq < Q_DEPTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    in_ready      = 1'b0;
    wr            = '0;
    wr.addr       = in_word.addr;
    wr.wdata      = in_word.wdata;
    map_rd_en     = 1'b0;
    val_rd_en     = 1'b0;
    ctrl          = '0;
    ctrl.last     = last_r;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (in_word.req_type)
            REQ_ROW_MAP: wr.row_map_we = 1'b1;
            REQ_COL_MAP: wr.col_map_we = 1'b1;
            REQ_X:       wr.x_we       = 1'b1;
            REQ_Q:       wr.q_we       = 1'b1;
            REQ_PAIR: begin
              map_rd_en = 1'b1;
              state_nxt = ST_MAP;
            end
            default: ;
          endcase
        end
      end
      ST_MAP: begin
        val_rd_en = 1'b1;
        state_nxt = ST_VAL;
      end
      ST_VAL: begin
        ctrl.mul_en = 1'b1;
        ctrl.hit    = hit_r;
        state_nxt   = ST_ACC;
      end
      ST_ACC: begin
        if (!last_r || out_free) begin
          ctrl.acc_en = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
    endcase
  end

  mgps_store u_store (
    .clk         (clk),
    .wr          (wr),
    .map_rd_en   (map_rd_en),
    .row_rd_addr (MAP_AW'(in_word.row_index)),
    .col_rd_addr (MAP_AW'(in_word.col_index)),
    .row_map_r   (row_map_r),
    .col_map_r   (col_map_r),
    .val_rd_en   (val_rd_en),
    .x_rd_addr   (X_AW'(ix)),
    .q_rd_addr   (Q_AW'(iq)),
    .x_val_r     (x_val_r),
    .q_val_r     (q_val_r)
  );

  mgps_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .x_val     (x_val_r),
    .q_val     (q_val_r),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_word  (out_word),
    .out_free  (out_free)
  );

  a_pair_reaches_acc: assert property (@(posedge clk) disable iff (!rst_n)
    pair_take |-> ##3 (state_r == ST_ACC))
    else $error("An accepted pair did not reach the accumulate step after three cycles.");

  a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == ST_ACC && last_r))
    else $error("A result word appeared without a last pair being accumulated.");

  a_last_waits_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ACC && last_r && out_valid && !out_ready) |=> (state_r == ST_ACC))
    else $error("A last pair left the accumulate step while the output register was full.");

  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MAP || state_r == ST_VAL) |-> (!in_ready && !wr.x_we && !wr.q_we))
    else $error("A word was taken or a table written while a pair was in flight.");

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// Testbench for the masked gather product-sum unit with random pair lists and a scoreboard.
module tb;
  import mgps_pkg::*;

  localparam int QUIET_CYCLES = 10;
  localparam int HOLD_CYCLES  = 300;

  class product_sum_tracker;
    logic [MAP_W-1:0]        row_map [MAP_LEN];
    logic [MAP_W-1:0]        col_map [MAP_LEN];
    logic [VAL_W-1:0]        x_vals [X_DEPTH];
    logic [VAL_W-1:0]        q_vals [Q_DEPTH];
    logic signed [ACC_W-1:0] acc;
    logic                    sat_seen;
    int unsigned             x_stride;
    int unsigned             q_rows;
    out_word_t               sums_due [$];
    int                      errors;

    function new();
      acc = '0;
      sat_seen = 1'b0;
      x_stride = 32'(X_STRIDE_RST);
      q_rows = 32'(Q_ROWS_RST);
      errors = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_W-1:0] value);
      if (idx == CFG_X_STRIDE) begin
        x_stride = 32'(value);
      end else begin
        q_rows = 32'(value);
      end
    endfunction

    function void add_product(logic signed [VAL_W-1:0] a, logic signed [VAL_W-1:0] b);
      logic signed [ACC_W-1:0] prod;
      logic signed [ACC_W:0]   sum;
      prod = a * b;
      sum = acc + prod;
      if (sum[ACC_W] != sum[ACC_W-1]) begin
        acc = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        sat_seen = 1'b1;
      end else begin
        acc = sum[ACC_W-1:0];
      end
    endfunction

    function void note_input(in_word_t w);
      int unsigned mi, mj, ix, iq;
      out_word_t   r;
      case (w.req_type)
        REQ_ROW_MAP: if (w.addr < MAP_LEN) row_map[w.addr] = w.wdata[MAP_W-1:0];
        REQ_COL_MAP: if (w.addr < MAP_LEN) col_map[w.addr] = w.wdata[MAP_W-1:0];
        REQ_X:       if (w.addr < X_DEPTH) x_vals[w.addr] = w.wdata;
        REQ_Q:       if (w.addr < Q_DEPTH) q_vals[w.addr] = w.wdata;
        REQ_PAIR: begin
          mi = 32'(row_map[w.row_index]);
          mj = 32'(col_map[w.col_index]);
          if (mi != 0 && mj != 0) begin
            ix = (mj - 1) * x_stride + (mi - 1);
            iq = 32'(w.col_index) * q_rows + 32'(w.row_index);
            if (ix < X_DEPTH && iq < Q_DEPTH) add_product(x_vals[ix], q_vals[iq]);
          end
          if (w.last) begin
            r.total = acc;
            r.saturated = sat_seen;
            sums_due.push_back(r);
            acc = '0;
            sat_seen = 1'b0;
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(out_word_t got);
      out_word_t want;
      if (sums_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got total=%0d saturated=%0b",
                 $time, got.total, got.saturated);
        return;
      end
      want = sums_due.pop_front();
      if (got.total !== want.total) begin
        errors++;
        $display("%0t: total mismatch, expected %0d, got %0d", $time, want.total, got.total);
      end
      if (got.saturated !== want.saturated) begin
        errors++;
        $display("%0t: saturated mismatch, expected %0b, got %0b",
                 $time, want.saturated, got.saturated);
      end
    endfunction

    function int pending();
      return sums_due.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  in_word_t             in_word;
  logic                 out_valid;
  logic                 out_ready;
  out_word_t            out_word;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  product_sum_tracker sb;

  logic [MAP_W-1:0] rmap_val [MAP_LEN];
  logic [MAP_W-1:0] cmap_val [MAP_LEN];
  bit               rmap_ok [MAP_LEN];
  bit               cmap_ok [MAP_LEN];
  bit               x_ok [X_DEPTH];
  bit               q_ok [Q_DEPTH];
  int unsigned      cur_x_stride = 64;
  int unsigned      cur_q_rows = 64;
  int               items_sent = 0;
  bit               no_idle = 1'b0;
  bit               hold_off_req = 1'b0;

  masked_gather_product_sum_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_input(in_word);
      if (out_valid && out_ready) sb.check_result(out_word);
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_reg_t'(cfg_index), cfg_data);
    end
  end

  function automatic int idle_len();
    int k;
    if (no_idle) return 0;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [VAL_W-1:0] value_word();
    int k;
    k = $urandom_range(0, 9);
    case (k)
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      4: return 32'h0001_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [VAL_W-1:0] map_word();
    logic [VAL_W-1:0] d;
    int               k;
    d = $urandom;
    k = $urandom_range(0, 19);
    if (k < 3) begin
      d[MAP_W-1:0] = '0;
    end else if (k == 3) begin
      d[MAP_W-1:0] = MAP_W'($urandom_range(65, 127));
    end else begin
      d[MAP_W-1:0] = MAP_W'($urandom_range(1, 64));
    end
    return d;
  endfunction

  task automatic push_word(input in_word_t w);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic write_table(input req_type_t t, input logic [ADDR_W-1:0] a,
                             input logic [VAL_W-1:0] d);
    in_word_t w;
    w.req_type = t;
    w.addr = a;
    w.wdata = d;
    w.row_index = IDX_W'($urandom);
    w.col_index = IDX_W'($urandom);
    w.last = 1'($urandom);
    case (t)
      REQ_ROW_MAP: if (a < MAP_LEN) begin
        rmap_ok[a] = 1'b1;
        rmap_val[a] = d[MAP_W-1:0];
      end
      REQ_COL_MAP: if (a < MAP_LEN) begin
        cmap_ok[a] = 1'b1;
        cmap_val[a] = d[MAP_W-1:0];
      end
      REQ_X: x_ok[a] = 1'b1;
      REQ_Q: q_ok[a] = 1'b1;
      default: ;
    endcase
    push_word(w);
  endtask

  task automatic send_pair(input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] col,
                           input logic last);
    in_word_t w;
    w.req_type = REQ_PAIR;
    w.addr = ADDR_W'($urandom);
    w.wdata = $urandom;
    w.row_index = row;
    w.col_index = col;
    w.last = last;
    push_word(w);
  endtask

  task automatic send_junk(input logic [2:0] t, input bit ones);
    in_word_t w;
    w = ones ? '1 : '0;
    w.req_type = t;
    push_word(w);
  endtask

  // Every map entry that a pair reads, and the X and Q entries of a hit, are written before the pair is sent.
  task automatic ready_pair(input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] col,
                            output bit hit, output int unsigned ix, output int unsigned iq);
    int unsigned mi, mj;
    if (!rmap_ok[row]) write_table(REQ_ROW_MAP, ADDR_W'(row), map_word());
    if (!cmap_ok[col]) write_table(REQ_COL_MAP, ADDR_W'(col), map_word());
    mi = 32'(rmap_val[row]);
    mj = 32'(cmap_val[col]);
    hit = 1'b0;
    ix = 0;
    iq = 0;
    if (mi != 0 && mj != 0) begin
      ix = (mj - 1) * cur_x_stride + (mi - 1);
      iq = 32'(col) * cur_q_rows + 32'(row);
      hit = (ix < X_DEPTH) && (iq < Q_DEPTH);
    end
    if (hit && !x_ok[ix]) write_table(REQ_X, ADDR_W'(ix), value_word());
    if (hit && !q_ok[iq]) write_table(REQ_Q, ADDR_W'(iq), value_word());
  endtask

  task automatic send_noise();
    int k;
    k = $urandom_range(0, 3);
    case (k)
      0: send_junk(3'($urandom_range(5, 7)), 1'($urandom_range(0, 1)));
      1: write_table($urandom_range(0, 1) ? REQ_ROW_MAP : REQ_COL_MAP,
                     ADDR_W'($urandom_range(MAP_LEN, 4095)), $urandom);
      2: write_table($urandom_range(0, 1) ? REQ_ROW_MAP : REQ_COL_MAP,
                     ADDR_W'($urandom_range(0, MAP_LEN - 1)), map_word());
      default: write_table($urandom_range(0, 1) ? REQ_X : REQ_Q, ADDR_W'($urandom),
                           value_word());
    endcase
  endtask

  task automatic random_list();
    logic [IDX_W-1:0] row, col;
    bit               hit;
    int unsigned      ix, iq;
    int               len;
    if ($urandom_range(0, 7) == 0) begin
      // Repeated extreme products drive the accumulator into saturation when the pair hits.
      row = IDX_W'($urandom);
      col = IDX_W'($urandom);
      ready_pair(row, col, hit, ix, iq);
      if (hit) begin
        write_table(REQ_X, ADDR_W'(ix), $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000);
        write_table(REQ_Q, ADDR_W'(iq), $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000);
      end
      len = $urandom_range(3, 6);
      for (int i = 0; i < len; i++) send_pair(row, col, i == len - 1);
    end else begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 11) == 0) send_noise();
        row = IDX_W'($urandom);
        col = IDX_W'($urandom);
        ready_pair(row, col, hit, ix, iq);
        send_pair(row, col, i == len - 1);
      end
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(input logic [CFG_W-1:0] xs, input logic [CFG_W-1:0] qs);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_X_STRIDE;
    cfg_data <= xs;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_Q_ROWS;
    cfg_data <= qs;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_x_stride = 32'(xs);
    cur_q_rows = 32'(qs);
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] xs, input logic [CFG_W-1:0] qs,
                           input int n_items, input bit squeeze);
    int target;
    drain();
    write_regs(xs, qs);
    if (squeeze) hold_off_req = 1'b1;
    target = items_sent + n_items;
    while (items_sent < target) random_list();
  endtask

  initial begin
    int ready_run, stall_run;
    ready_run = 0;
    stall_run = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (stall_run > 0) begin
        out_ready <= 1'b0;
        stall_run--;
      end else if (ready_run > 0) begin
        out_ready <= 1'b1;
        ready_run--;
      end else begin
        out_ready <= 1'b1;
        ready_run = $urandom_range(0, 24);
        stall_run = idle_len();
      end
    end
  end

  initial begin
    #2_000_000;
    $display("tb: FAIL");
    $finish;
  end

  initial begin
    sb = new();
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_word <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_X_STRIDE;
    cfg_data <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, run with the strides left at their reset values.
    write_table(REQ_ROW_MAP, ADDR_W'(0), 32'h8000_0001);
    write_table(REQ_ROW_MAP, ADDR_W'(1), 32'h7FFF_FF80);
    write_table(REQ_ROW_MAP, ADDR_W'(2), 32'h0000_0064);
    write_table(REQ_ROW_MAP, ADDR_W'(4095), 32'hFFFF_FFFF);
    write_table(REQ_COL_MAP, ADDR_W'(0), 32'h0000_0001);
    write_table(REQ_COL_MAP, ADDR_W'(63), 32'hFFFF_FFC0);
    write_table(REQ_COL_MAP, ADDR_W'(1), 32'h0000_0000);
    write_table(REQ_X, ADDR_W'(0), 32'h8000_0000);
    write_table(REQ_Q, ADDR_W'(0), 32'h8000_0000);
    write_table(REQ_X, ADDR_W'(4032), 32'h7FFF_FFFF);
    write_table(REQ_Q, ADDR_W'(4032), 32'h8000_0000);
    send_junk(3'd5, 1'b0);
    send_junk(3'd7, 1'b1);
    send_pair(IDX_W'(0), IDX_W'(0), 1'b0);
    send_pair(IDX_W'(0), IDX_W'(0), 1'b0);
    send_pair(IDX_W'(0), IDX_W'(0), 1'b0);
    send_pair(IDX_W'(0), IDX_W'(63), 1'b1);
    send_pair(IDX_W'(0), IDX_W'(63), 1'b0);
    send_pair(IDX_W'(0), IDX_W'(63), 1'b0);
    send_pair(IDX_W'(0), IDX_W'(63), 1'b0);
    send_pair(IDX_W'(2), IDX_W'(63), 1'b1);
    send_pair(IDX_W'(1), IDX_W'(0), 1'b1);
    send_pair(IDX_W'(0), IDX_W'(1), 1'b0);
    send_pair(IDX_W'(0), IDX_W'(0), 1'b1);

    run_phase(7'd64, 7'd64, 170, 1'b0);
    run_phase(7'd1, 7'd1, 160, 1'b0);
    run_phase(7'd1, 7'd64, 160, 1'b0);
    run_phase(7'd64, 7'd1, 160, 1'b0);
    run_phase(CFG_W'($urandom_range(1, 64)), CFG_W'($urandom_range(1, 64)), 160, 1'b1);
    no_idle = 1'b1;
    run_phase(CFG_W'($urandom_range(1, 64)), CFG_W'($urandom_range(1, 64)), 160, 1'b0);
    no_idle = 1'b0;
    run_phase(7'd0, 7'd127, 120, 1'b0);
    run_phase(CFG_W'($urandom_range(1, 64)), CFG_W'($urandom_range(1, 64)), 200, 1'b0);
    run_phase(CFG_W'($urandom_range(1, 64)), CFG_W'($urandom_range(1, 64)), 150, 1'b0);
    drain();

    if (sb.errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
